// ===== design/bla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_pkg
// shared widths, register indexes and level helpers for the battery level
// averager
// ----------------------------------------------------------------------------
package bla_pkg;

  localparam int SAMPLE_W  = 12;   // one adc word, millivolts
  localparam int AVG_W     = 12;   // block average, never above the sample range
  localparam int MV_W      = 16;   // scaled millivolts
  localparam int EMA_W     = 24;   // filter state, q16.8 millivolts
  localparam int SIZE_W    = 9;
  localparam int HYST_W    = 10;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int GAIN_FRAC = 12;   // q4.12 divider gain
  localparam int ALPHA_W   = 16;   // q0.16 filter weight

  typedef logic [LVL_W-1:0]     level_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SAMPLES   = 4'd0;
  localparam cfg_idx_t REG_GAIN      = 4'd1;
  localparam cfg_idx_t REG_ALPHA     = 4'd2;
  localparam cfg_idx_t REG_HYST      = 4'd3;
  localparam cfg_idx_t REG_THR_FULL  = 4'd4;
  localparam cfg_idx_t REG_THR_HIGH  = 4'd5;
  localparam cfg_idx_t REG_THR_MID   = 4'd6;
  localparam cfg_idx_t REG_THR_LOW   = 4'd7;

  localparam level_t LVL_EMPTY = 3'd0;
  localparam level_t LVL_LOW   = 3'd1;
  localparam level_t LVL_MID   = 3'd2;
  localparam level_t LVL_HIGH  = 3'd3;
  localparam level_t LVL_FULL  = 3'd4;

  // level index to percent
  function automatic logic [PCT_W-1:0] level_pct(input level_t lvl);
    logic [PCT_W-1:0] p;
    case (lvl)
      LVL_LOW:  p = 7'd25;
      LVL_MID:  p = 7'd50;
      LVL_HIGH: p = 7'd75;
      LVL_FULL: p = 7'd100;
      default:  p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/battery_level_averager_hysteresis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_averager_hysteresis
// block averager, divider gain scaling, ema filter and five-level charge
// quantizer with hysteresis
// ----------------------------------------------------------------------------
// in_*  : one adc millivolt word per accepted item; each yields one out_* word
// out_* : result word in an output register, held while out_stall is high;
//         block_done marks words that closed a block
// cfg_* : register writes, cfg_ready always high, unknown index dropped;
//         write only while the block is idle
// a word that does not close a block reaches the output register on the next
// edge, so such words stream one per cycle while the output is not stalled
// a word that closes a block goes through a bit-serial divide of the sum by
// the count (12-bit quotient), three passes through the shared 17x24
// multiplier (scale, new-value term, old-value term), the saturation, the sum
// and the level update, the first block skipping the last two passes and the
// sum; in_stall stays high until its result word is in the output register
// sync active-low reset restores the register defaults, clears sum, count,
// filter and primed flag, and sets the level to 100 percent
// a held out_stall stalls the input once the output register is full
// ----------------------------------------------------------------------------
module battery_level_averager_hysteresis #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bla_pkg::SAMPLE_W-1:0] in_sample_mv,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bla_pkg::PCT_W-1:0]   out_charge_percent,
  output logic [bla_pkg::MV_W-1:0]    out_filtered_mv,
  output logic [bla_pkg::MV_W-1:0]    out_block_mv,
  output logic                        out_block_done,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bla_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bla_pkg::*;

  // count holds up to MAX_SAMPLES, sum up to MAX_SAMPLES full-scale words
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam logic [31:0] MAX_U = MAX_SAMPLES;
  localparam logic [3:0]  DIV_LAST = 4'(AVG_W - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_SAT   = 3'd3;
  localparam logic [2:0] ST_MNEW  = 3'd4;
  localparam logic [2:0] ST_MOLD  = 3'd5;
  localparam logic [2:0] ST_SUM   = 3'd6;
  localparam logic [2:0] ST_QUANT = 3'd7;

  // configuration registers
  logic [SIZE_W-1:0]  samples_r;
  logic [MV_W-1:0]    gain_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [HYST_W-1:0]  hyst_r;
  logic [MV_W-1:0]    thr_full_r;
  logic [MV_W-1:0]    thr_high_r;
  logic [MV_W-1:0]    thr_mid_r;
  logic [MV_W-1:0]    thr_low_r;

  // block and filter state
  logic [2:0]         state_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   count_r;
  logic [MV_W-1:0]    block_r;
  logic [EMA_W-1:0]   ema_r;
  logic               primed_r;
  level_t             level_r;

  // divide and multiply datapath
  logic [3:0]         step_r;
  logic [CNT_W-1:0]   rem_r;
  logic [AVG_W-1:0]   dvd_r;     // dividend bits in, quotient bits out
  logic [CNT_W-1:0]   divisor_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  acc_r;

  // output register
  logic               out_valid_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [MV_W-1:0]    out_filt_r;
  logic [MV_W-1:0]    out_block_r;
  logic               out_done_r;

  // effective block size, zero taken as one and clamped to MAX_SAMPLES
  logic [CNT_W-1:0]   block_size;
  always_comb begin
    if (samples_r == '0) begin
      block_size = CNT_W'(1);
    end else if ({23'd0, samples_r} > MAX_U) begin
      block_size = CNT_W'(MAX_U);
    end else begin
      block_size = CNT_W'({23'd0, samples_r});
    end
  end

  logic out_free;
  logic in_fire;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // accumulate the incoming word
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic             closes_block;
  assign sum_nxt      = sum_r + SUM_W'(in_sample_mv);
  assign count_nxt    = count_r + CNT_W'(1);
  assign closes_block = (count_nxt >= block_size);

  // output register loads a word: a plain sample, or the end of a block
  logic out_load;
  assign out_load = (state_r == ST_IDLE && in_fire && !closes_block) ||
                    (state_r == ST_QUANT && out_free);

  // restoring divide step, remainder always below the divisor
  logic [CNT_W:0]   div_trial;
  logic [CNT_W:0]   div_diff;
  logic             div_ge;
  logic [CNT_W-1:0] rem_nxt;
  logic [AVG_W-1:0] dvd_nxt;
  assign div_trial = {rem_r, dvd_r[AVG_W-1]};
  assign div_ge    = (div_trial >= {1'b0, divisor_r});
  assign div_diff  = div_trial - {1'b0, divisor_r};
  assign rem_nxt   = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
  assign dvd_nxt   = {dvd_r[AVG_W-2:0], div_ge};

  // shared multiplier operand select
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_nxt;
  always_comb begin
    case (state_r)
      ST_MNEW: begin
        mul_a = MUL_A_W'(alpha_r);
        mul_b = {block_r, 8'd0};
      end
      ST_MOLD: begin
        // weight of the old value, 65536 when alpha is zero
        mul_a = 17'h10000 - MUL_A_W'(alpha_r);
        mul_b = ema_r;
      end
      default: begin
        mul_a = MUL_A_W'(gain_r);
        mul_b = MUL_B_W'(dvd_r);
      end
    endcase
  end
  assign prod_nxt = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // scaled average with saturation at full 16-bit millivolts
  logic [MV_W-1:0] block_nxt;
  assign block_nxt = (prod_r[PROD_W-1:GAIN_FRAC+MV_W] != '0) ? '1 :
                     prod_r[GAIN_FRAC +: MV_W];

  // ema update, both terms already registered
  logic [PROD_W-1:0] ema_sum;
  assign ema_sum = acc_r + prod_r;

  // one-step hysteresis quantizer on the full q16.8 filter value
  logic [MV_W-1:0]  thr_up;
  logic [MV_W-1:0]  thr_dn;
  logic [MV_W:0]    thr_dn_lo;
  level_t           level_nxt;
  always_comb begin
    case (level_r)
      LVL_EMPTY: thr_up = thr_low_r;
      LVL_LOW:   thr_up = thr_mid_r;
      LVL_MID:   thr_up = thr_high_r;
      default:   thr_up = thr_full_r;
    endcase
    case (level_r)
      LVL_LOW:  thr_dn = thr_low_r;
      LVL_MID:  thr_dn = thr_mid_r;
      LVL_HIGH: thr_dn = thr_high_r;
      default:  thr_dn = thr_full_r;
    endcase
    thr_dn_lo = {1'b0, thr_dn} - {7'd0, hyst_r};
    level_nxt = level_r;
    if (level_r != LVL_FULL && ema_r >= {thr_up, 8'd0}) begin
      level_nxt = level_r + level_t'(1);
    end else if (level_r != LVL_EMPTY && !thr_dn_lo[MV_W] &&
                 ema_r < {thr_dn_lo[MV_W-1:0], 8'd0}) begin
      // threshold below the margin never drops
      level_nxt = level_r - level_t'(1);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r  <= 9'd32;
      gain_r     <= 16'd16508;
      alpha_r    <= 16'd13107;
      hyst_r     <= 10'd80;
      thr_full_r <= 16'd12100;
      thr_high_r <= 16'd11800;
      thr_mid_r  <= 16'd11400;
      thr_low_r  <= 16'd10950;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLES:  samples_r  <= cfg_data[SIZE_W-1:0];
        REG_GAIN:     gain_r     <= cfg_data;
        REG_ALPHA:    alpha_r    <= cfg_data;
        REG_HYST:     hyst_r     <= cfg_data[HYST_W-1:0];
        REG_THR_FULL: thr_full_r <= cfg_data;
        REG_THR_HIGH: thr_high_r <= cfg_data;
        REG_THR_MID:  thr_mid_r  <= cfg_data;
        REG_THR_LOW:  thr_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // output valid: set on a load, cleared once the receiver takes the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      block_r     <= '0;
      ema_r       <= '0;
      primed_r    <= 1'b0;
      level_r     <= LVL_FULL;
      step_r      <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (closes_block) begin
              // start the divide on the full sum, quotient fits 12 bits
              rem_r     <= sum_nxt[SUM_W-1:AVG_W];
              dvd_r     <= sum_nxt[AVG_W-1:0];
              divisor_r <= count_nxt;
              step_r    <= '0;
              sum_r     <= '0;
              count_r   <= '0;
              state_r   <= ST_DIV;
            end else begin
              sum_r       <= sum_nxt;
              count_r     <= count_nxt;
              out_pct_r   <= level_pct(level_r);
              out_filt_r  <= ema_r[EMA_W-1:8];
              out_block_r <= block_r;
              out_done_r  <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          dvd_r  <= dvd_nxt;
          step_r <= step_r + 4'd1;
          if (step_r == DIV_LAST) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_r  <= prod_nxt;
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          block_r <= block_nxt;
          if (!primed_r) begin
            // first block loads the filter directly
            ema_r    <= {block_nxt, 8'd0};
            primed_r <= 1'b1;
            state_r  <= ST_QUANT;
          end else begin
            state_r <= ST_MNEW;
          end
        end
        ST_MNEW: begin
          prod_r  <= prod_nxt;
          state_r <= ST_MOLD;
        end
        ST_MOLD: begin
          acc_r   <= prod_r;
          prod_r  <= prod_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          ema_r   <= ema_sum[ALPHA_W +: EMA_W];
          state_r <= ST_QUANT;
        end
        ST_QUANT: begin
          if (out_free) begin
            level_r     <= level_nxt;
            out_pct_r   <= level_pct(level_nxt);
            out_filt_r  <= ema_r[EMA_W-1:8];
            out_block_r <= block_r;
            out_done_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_charge_percent = out_pct_r;
  assign out_filtered_mv    = out_filt_r;
  assign out_block_mv       = out_block_r;
  assign out_block_done     = out_done_r;

endmodule

// ===== test/bla_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_checker
// watches the sample, result and register channels of the battery level
// averager, keeps its own copy of the block sum, filter and level, and
// compares every result word field by field against the oldest prediction
// ----------------------------------------------------------------------------
module bla_checker #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bla_pkg::SAMPLE_W-1:0]  in_sample_mv,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bla_pkg::PCT_W-1:0]     out_charge_percent,
  input  logic [bla_pkg::MV_W-1:0]      out_filtered_mv,
  input  logic [bla_pkg::MV_W-1:0]      out_block_mv,
  input  logic                          out_block_done,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [bla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bla_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            pending
);
  import bla_pkg::*;

  localparam int DEF_BLOCK_LEN = 32;
  localparam int DEF_GAIN      = 16508;
  localparam int DEF_ALPHA     = 13107;
  localparam int DEF_HYST      = 80;
  localparam int DEF_THR_FULL  = 12100;
  localparam int DEF_THR_HIGH  = 11800;
  localparam int DEF_THR_MID   = 11400;
  localparam int DEF_THR_LOW   = 10950;

  typedef struct packed {
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  filt;
    logic [MV_W-1:0]  blk;
    logic             done;
  } gauge_word_t;

  // register copy
  logic [SIZE_W-1:0]  block_len;
  logic [MV_W-1:0]    gain;
  logic [ALPHA_W-1:0] alpha;
  logic [HYST_W-1:0]  hyst;
  logic [MV_W-1:0]    thr_full, thr_high, thr_mid, thr_low;

  // averaging and filter state
  logic [19:0]        blk_sum;
  logic [SIZE_W-1:0]  blk_count;
  logic [MV_W-1:0]    last_block_mv;
  logic [EMA_W-1:0]   ema_q8;
  logic               primed;
  level_t             level;

  gauge_word_t        gauge_words[$];
  gauge_word_t        want;

  function automatic logic [MV_W-1:0] bound_of(input level_t idx);
    case (idx)
      LVL_EMPTY: return thr_low;
      LVL_LOW:   return thr_mid;
      LVL_MID:   return thr_high;
      default:   return thr_full;
    endcase
  endfunction

  // one step up checked first, then one step down below the margin
  function automatic level_t step_level(input level_t cur, input logic [EMA_W-1:0] v);
    longint unsigned vv, t, hy;
    vv = v;
    hy = hyst;
    if (cur < LVL_FULL) begin
      t = bound_of(cur);
      if (vv >= (t << 8)) return cur + 3'd1;
    end
    if (cur > LVL_EMPTY) begin
      t = bound_of(cur - 3'd1);
      if (t >= hy && vv < ((t - hy) << 8)) return cur - 3'd1;
    end
    return cur;
  endfunction

  task automatic absorb_sample(input logic [SAMPLE_W-1:0] mv);
    int unsigned     span, avg, pct_i;
    longint unsigned scaled, a, fresh, old, mix;
    gauge_word_t     w;
    span = block_len;
    if (span < 1) span = 1;
    if (span > MAX_SAMPLES) span = MAX_SAMPLES;
    blk_sum   = blk_sum + 20'(mv);
    blk_count = blk_count + SIZE_W'(1);
    w.done    = 1'b0;
    if (blk_count >= span) begin
      avg    = blk_sum / blk_count;
      scaled = avg;
      scaled = (scaled * gain) >> GAIN_FRAC;
      if (scaled > 65535) scaled = 65535;
      last_block_mv = scaled[MV_W-1:0];
      if (!primed) begin
        ema_q8 = {last_block_mv, 8'h00};
        primed = 1'b1;
      end else begin
        a      = alpha;
        fresh  = {last_block_mv, 8'h00};
        old    = ema_q8;
        mix    = a * fresh + (64'd65536 - a) * old;
        ema_q8 = mix[EMA_W+15:16];
      end
      level     = step_level(level, ema_q8);
      blk_sum   = '0;
      blk_count = '0;
      w.done    = 1'b1;
    end
    pct_i  = 25 * level;
    w.pct  = pct_i[PCT_W-1:0];
    w.filt = ema_q8[EMA_W-1:8];
    w.blk  = last_block_mv;
    gauge_words.push_back(w);
  endtask

  task automatic apply_write(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_SAMPLES:  block_len = d[SIZE_W-1:0];
      REG_GAIN:     gain      = d;
      REG_ALPHA:    alpha     = d;
      REG_HYST:     hyst      = d[HYST_W-1:0];
      REG_THR_FULL: thr_full  = d;
      REG_THR_HIGH: thr_high  = d;
      REG_THR_MID:  thr_mid   = d;
      REG_THR_LOW:  thr_low   = d;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      block_len     = SIZE_W'(DEF_BLOCK_LEN);
      gain          = MV_W'(DEF_GAIN);
      alpha         = ALPHA_W'(DEF_ALPHA);
      hyst          = HYST_W'(DEF_HYST);
      thr_full      = MV_W'(DEF_THR_FULL);
      thr_high      = MV_W'(DEF_THR_HIGH);
      thr_mid       = MV_W'(DEF_THR_MID);
      thr_low       = MV_W'(DEF_THR_LOW);
      blk_sum       = '0;
      blk_count     = '0;
      last_block_mv = '0;
      ema_q8        = '0;
      primed        = 1'b0;
      level         = LVL_FULL;
      gauge_words.delete();
      mismatches    = 0;
      pending       = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gauge_words.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want = gauge_words.pop_front();
          check_field("charge_percent", want.pct, out_charge_percent);
          check_field("filtered_mv", want.filt, out_filtered_mv);
          check_field("block_mv", want.blk, out_block_mv);
          check_field("block_done", want.done, out_block_done);
        end
      end
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) absorb_sample(in_sample_mv);
      pending = gauge_words.size();
    end
  end

endmodule

// ===== test/tb_battery_level_averager_hysteresis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_averager_hysteresis
// drives adc sample words and register writes into the averager, stalls the
// result side at random, and leaves prediction and comparison to bla_checker
// ----------------------------------------------------------------------------
module tb_battery_level_averager_hysteresis;
  import bla_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 24;

  // indexes past the register list, must be dropped
  localparam cfg_idx_t REG_UNUSED_LO = 4'd8;
  localparam cfg_idx_t REG_UNUSED_HI = 4'd15;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample_mv = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [PCT_W-1:0]     out_charge_percent;
  logic [MV_W-1:0]      out_filtered_mv;
  logic [MV_W-1:0]      out_block_mv;
  logic                 out_block_done;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;

  int mismatches;
  int pending;
  int cycle_count = 0;
  bit quiet = 1'b0;       // both sides run without gaps while set

  battery_level_averager_hysteresis dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_mv       (in_sample_mv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_percent (out_charge_percent),
    .out_filtered_mv    (out_filtered_mv),
    .out_block_mv       (out_block_mv),
    .out_block_done     (out_block_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  bla_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_mv       (in_sample_mv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_charge_percent (out_charge_percent),
    .out_filtered_mv    (out_filtered_mv),
    .out_block_mv       (out_block_mv),
    .out_block_done     (out_block_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one sample word; valid stays high on return so back-to-back words never
  // see valid dropped and raised in the same step
  task automatic send_sample(input int mv);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_mv <= mv[SAMPLE_W-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // register write; cfg_valid is lowered once by end_writes after a group
  task automatic write_reg(input cfg_idx_t idx, input int unsigned d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d[CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every predicted word has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_thresholds(input int full, input int high, input int mid,
                                  input int low);
    write_reg(REG_THR_FULL, full);
    write_reg(REG_THR_HIGH, high);
    write_reg(REG_THR_MID, mid);
    write_reg(REG_THR_LOW, low);
  endtask

  // result side: a fresh stall length per word, stall held low until taken
  initial begin : receiver
    int hold;
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int phase, k, n_items, sent, kind;
    int len, gain, alpha, hyst, center, c_lo, c_hi, dir, base, low, mid, high, full;
    int r, mv;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed ----
    // reset settings: a partial block, nothing closes yet, block_mv still 0
    send_sample(0);
    send_sample(4095);
    send_sample(1);

    // block size field masked to zero, so size one; the three words already
    // summed make the next word close a block of four. stray indexes must
    // not land on any register
    drain();
    write_reg(REG_SAMPLES, 32'h0000_FE00);
    write_reg(REG_UNUSED_LO, 32'h0000_0001);
    write_reg(REG_UNUSED_HI, 32'h0000_FFFF);
    end_writes();
    send_sample(2048);        // primes the filter, level starts falling
    send_sample(3000);
    send_sample(3000);
    send_sample(3000);

    // max gain and weight, margin field overfilled, thresholds at zero:
    // every block steps up and no fall is possible below the margin
    drain();
    write_reg(REG_GAIN, 32'h0000_FFFF);
    write_reg(REG_ALPHA, 32'h0000_FFFF);
    write_reg(REG_HYST, 32'h0000_FFFF);
    write_thresholds(0, 0, 0, 0);
    end_writes();
    repeat (4) send_sample(4095);
    send_sample(0);

    // zero gain and weight: filter frozen, thresholds at the top, level
    // walks down one step per block and sticks at zero
    drain();
    write_reg(REG_GAIN, 0);
    write_reg(REG_ALPHA, 0);
    write_reg(REG_HYST, 0);
    write_thresholds(65535, 65535, 65535, 65535);
    end_writes();
    send_sample(4095);
    send_sample(0);
    send_sample(4095);
    send_sample(0);
    send_sample(2);

    // unity gain and near-full weight pull the filter just below the threshold,
    // so the level holds at empty
    drain();
    write_reg(REG_GAIN, 4096);
    write_reg(REG_ALPHA, 65535);
    write_thresholds(1000, 1000, 1000, 1000);
    end_writes();
    send_sample(1000);
    send_sample(999);
    send_sample(1000);

    // ---- random phases ----
    // each phase: new settings, a slowly moving battery voltage around the
    // thresholds so the level keeps crossing, plus wild words now and then
    sent = 0;
    for (phase = 0; sent < ITEM_TARGET; phase++) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // back to the power-on settings
        write_reg(REG_SAMPLES, 32);
        write_reg(REG_GAIN, 16508);
        write_reg(REG_ALPHA, 13107);
        write_reg(REG_HYST, 80);
        write_thresholds(12100, 11800, 11400, 10950);
        center  = $urandom_range(2650, 3050);
        n_items = 100;
      end else begin
        kind = $urandom_range(0, 9);
        if (phase == 2) len = 511;          // clamps to the largest block
        else if (kind <= 6) len = $urandom_range(1, 8);
        else if (kind <= 8) len = $urandom_range(9, 40);
        else len = 0;

        case ($urandom_range(0, 7))
          0:       gain = 0;
          1:       gain = 65535;
          default: gain = $urandom_range(12000, 20000);
        endcase
        case ($urandom_range(0, 7))
          0:       alpha = 0;
          1:       alpha = 65535;
          2:       alpha = $urandom_range(0, 65535);
          default: alpha = $urandom_range(4000, 30000);
        endcase
        hyst   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 150);
        center = $urandom_range(2400, 3300);
        base   = (center * gain) >>> GAIN_FRAC;

        if ($urandom_range(0, 5) == 0) begin
          // unordered thresholds anywhere in range
          full = $urandom_range(0, 65535);
          high = $urandom_range(0, 65535);
          mid  = $urandom_range(0, 65535);
          low  = $urandom_range(0, 65535);
        end else begin
          low  = clip(base - 600 + $urandom_range(0, 300), 0, 65535);
          mid  = clip(low + $urandom_range(0, 400), 0, 65535);
          high = clip(mid + $urandom_range(0, 400), 0, 65535);
          full = clip(high + $urandom_range(0, 400), 0, 65535);
        end

        // junk above the field width must be dropped
        write_reg(REG_SAMPLES, ($urandom_range(0, 127) << SIZE_W) | len);
        write_reg(REG_GAIN, gain);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_HYST, ($urandom_range(0, 63) << HYST_W) | hyst);
        write_thresholds(full, high, mid, low);
        n_items = (phase == 2) ? 270 : $urandom_range(60, 140);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
      end_writes();

      c_lo = clip(center - 300, 0, 4095);
      c_hi = clip(center + 300, 0, 4095);
      dir  = $urandom_range(0, 1) ? 1 : -1;
      for (k = 0; k < n_items; k++) begin
        if (k % 40 == 39) quiet = ($urandom_range(0, 3) == 0);
        // now and then wait for the pipe to empty mid-phase
        if ($urandom_range(0, 79) == 0) drain();

        r = $urandom_range(0, 9);
        if (r == 0) mv = $urandom_range(0, 4095);
        else if (r == 1) mv = $urandom_range(0, 1) ? 4095 : 0;
        else mv = clip(center + $urandom_range(0, 60) - 30, 0, 4095);
        send_sample(mv);
        sent++;

        // voltage drifts one way, turning at the edges or at random
        center = clip(center + dir * $urandom_range(0, 6), c_lo, c_hi);
        if (center == c_lo) dir = 1;
        else if (center == c_hi) dir = -1;
        else if ($urandom_range(0, 49) == 0) dir = -dir;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
